@@ hdl/dwarf_abp_pkg.sv @@
// Shared types and constants for the DWARF abbreviation table parser.
package dwarf_abp_pkg;

    // Record kinds carried on the result channel.
    localparam logic [1:0] KIND_PAIR      = 2'd0;
    localparam logic [1:0] KIND_ENTRY_END = 2'd1;
    localparam logic [1:0] KIND_TABLE_END = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    // Tag value of a compile-unit entry.
    localparam logic [31:0] TAG_COMPILE_UNIT = 32'h0000_0011;

    // Longest LEB128 value in bytes, and the index of its last byte, which may not continue.
    localparam int unsigned LEB_MAX_BYTES = 5;
    localparam logic [2:0]  LEB_LAST_IDX  = 3'(LEB_MAX_BYTES - 1);

    // One result record.
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] abbrev_code;
        logic [31:0] attribute_code;
        logic [31:0] form_code;
    } t_record;

endpackage

@@ hdl/dwarf_abp_if.sv @@
// Channel interfaces: section byte stream in, decoded records out.
interface dwarf_abp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] section_byte;
    logic       section_last;

    modport source (output valid, output section_byte, output section_last, input ready);
    modport sink   (input valid, input section_byte, input section_last, output ready);
endinterface

interface dwarf_abp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [31:0] abbrev_code;
    logic [31:0] attribute_code;
    logic [31:0] form_code;

    modport source (output valid, output record_kind, output abbrev_code,
                    output attribute_code, output form_code, input ready);
    modport sink   (input valid, input record_kind, input abbrev_code,
                    input attribute_code, input form_code, output ready);
endinterface

@@ hdl/dwarf_abp_core.sv @@
// Byte-at-a-time parser state: LEB128 decoding and entry phase tracking.
module dwarf_abp_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output logic                   o_emit,
    output dwarf_abp_pkg::t_record o_record
);

    typedef enum logic [2:0] {
        PH_CODE  = 3'd0,
        PH_TAG   = 3'd1,
        PH_HASCH = 3'd2,
        PH_ATTR  = 3'd3,
        PH_FORM  = 3'd4
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [31:0] r_acc,     n_acc;
    logic [2:0]  r_cnt,     n_cnt;
    logic [31:0] r_code,    n_code;
    logic [31:0] r_held,    n_held;
    logic        r_cu,      n_cu;
    logic        r_stopped, n_stopped;

    logic [4:0]  shift_amt;
    logic [31:0] acc_merged;
    logic        do_quit;

    // Merge the payload bits of this byte at the current group position.
    assign shift_amt  = 5'(r_cnt) * 5'd7;
    assign acc_merged = r_acc | ({25'd0, i_byte[6:0]} << shift_amt);

    // Next-state and record selection for one accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_code    = r_code;
        n_held    = r_held;
        n_cu      = r_cu;
        n_stopped = r_stopped;
        o_emit    = 1'b0;
        o_record  = '0;
        do_quit   = 1'b0;

        if (i_accept && !r_stopped) begin
            if (r_phase == PH_HASCH) begin
                if (i_last) begin
                    o_emit               = 1'b1;
                    o_record.record_kind = dwarf_abp_pkg::KIND_ERROR;
                    o_record.abbrev_code = r_code;
                    do_quit              = 1'b1;
                end else begin
                    n_phase = PH_ATTR;
                end
            end else if (i_byte[7]) begin
                // Continuation byte: overlong or cut off by the section end.
                if (r_cnt >= dwarf_abp_pkg::LEB_LAST_IDX || i_last) begin
                    o_emit               = 1'b1;
                    o_record.record_kind = dwarf_abp_pkg::KIND_ERROR;
                    o_record.abbrev_code = r_code;
                    do_quit              = 1'b1;
                end else begin
                    n_acc = acc_merged;
                    n_cnt = r_cnt + 3'd1;
                end
            end else begin
                // Value complete.
                n_acc = '0;
                n_cnt = '0;
                case (r_phase)
                    PH_TAG, PH_ATTR: begin
                        if (i_last) begin
                            o_emit               = 1'b1;
                            o_record.record_kind = dwarf_abp_pkg::KIND_ERROR;
                            o_record.abbrev_code = r_code;
                            do_quit              = 1'b1;
                        end else if (r_phase == PH_TAG) begin
                            n_cu    = (acc_merged == dwarf_abp_pkg::TAG_COMPILE_UNIT);
                            n_phase = PH_HASCH;
                        end else begin
                            n_held  = acc_merged;
                            n_phase = PH_FORM;
                        end
                    end
                    PH_FORM: begin
                        if (i_last) begin
                            o_emit               = 1'b1;
                            o_record.record_kind = dwarf_abp_pkg::KIND_ERROR;
                            o_record.abbrev_code = r_code;
                            do_quit              = 1'b1;
                        end else if (r_held == '0 && acc_merged == '0) begin
                            n_phase              = PH_CODE;
                            o_emit               = r_cu;
                            o_record.record_kind = dwarf_abp_pkg::KIND_ENTRY_END;
                            o_record.abbrev_code = r_code;
                        end else if (r_held == '0 || acc_merged == '0) begin
                            o_emit               = 1'b1;
                            o_record.record_kind = dwarf_abp_pkg::KIND_ERROR;
                            o_record.abbrev_code = r_code;
                            do_quit              = 1'b1;
                        end else begin
                            n_phase                 = PH_ATTR;
                            o_emit                  = r_cu;
                            o_record.record_kind    = dwarf_abp_pkg::KIND_PAIR;
                            o_record.abbrev_code    = r_code;
                            o_record.attribute_code = r_held;
                            o_record.form_code      = acc_merged;
                        end
                    end
                    default: begin
                        // Abbreviation code; unused phase codes land here too.
                        if (acc_merged == '0) begin
                            o_emit               = 1'b1;
                            o_record.record_kind = dwarf_abp_pkg::KIND_TABLE_END;
                            do_quit              = 1'b1;
                        end else if (i_last) begin
                            o_emit               = 1'b1;
                            o_record.record_kind = dwarf_abp_pkg::KIND_ERROR;
                            o_record.abbrev_code = r_code;
                            do_quit              = 1'b1;
                        end else begin
                            n_code  = acc_merged;
                            n_phase = PH_TAG;
                        end
                    end
                endcase
            end
            if (do_quit) begin
                n_stopped = 1'b1;
            end
        end

        // The final byte of the section always returns the parser to reset.
        if (i_accept && i_last) begin
            n_phase   = PH_CODE;
            n_acc     = '0;
            n_cnt     = '0;
            n_code    = '0;
            n_held    = '0;
            n_cu      = 1'b0;
            n_stopped = 1'b0;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CODE;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_code    <= '0;
            r_held    <= '0;
            r_cu      <= 1'b0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_code    <= n_code;
            r_held    <= n_held;
            r_cu      <= n_cu;
            r_stopped <= n_stopped;
        end
    end

    // A stopped parser stays silent until the section ends.
    a_silent_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !o_emit)
        else $error("record emitted while parser is stopped");

    // The byte counter never passes the last allowed LEB128 byte.
    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dwarf_abp_pkg::LEB_LAST_IDX)
        else $error("LEB128 byte count out of range");

    // The section's final byte leaves the parser expecting a fresh code.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_phase == PH_CODE && !r_stopped && r_cnt == '0))
        else $error("parser not back at reset after final section byte");

    // Pending LEB128 bits only exist while a value is being read.
    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_acc == '0))
        else $error("stale LEB128 accumulator");

endmodule

@@ hdl/dwarf_abbrev_table_parser_unit.sv @@
// Top level of the DWARF abbreviation table parser with its output buffer.
//
//   channel     dir  payload                                          beat
//   i_section   in   section_byte[7:0], section_last                  one section byte
//   o_record    out  record_kind[1:0], abbrev_code, attribute_code,   one record
//                    form_code (32 bits each)
//
// One byte is taken per cycle while i_section.ready is high; its record, if any, goes to
// the output register, or to the skid register while that one holds a record. The per-byte
// work is a single 7-bit shift and OR into the LEB128 accumulator plus the phase update.
// A skid register behind the output register lets one more byte in while a record
// waits; the input stalls only when both hold a record.
// Reset (i_rst_n low, synchronous) clears the parser and empties both registers.
module dwarf_abbrev_table_parser_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    dwarf_abp_byte_if.sink          i_section,
    dwarf_abp_rec_if.source         o_record
);

    logic                   accept;
    logic                   core_emit;
    dwarf_abp_pkg::t_record core_record;
    logic                   produce;

    logic                   r_out_valid;
    dwarf_abp_pkg::t_record r_out;
    logic                   r_skid_valid;
    dwarf_abp_pkg::t_record r_skid;

    assign i_section.ready = !r_skid_valid;
    assign accept          = i_section.valid && i_section.ready;
    assign produce         = accept && core_emit;

    dwarf_abp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_section.section_byte),
        .i_last   (i_section.section_last),
        .o_emit   (core_emit),
        .o_record (core_record)
    );

    // Output register with a one-entry skid buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_record.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload of the two buffer stages.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_record.ready) begin
            r_out <= r_skid_valid ? r_skid : core_record;
        end else if (produce) begin
            r_skid <= core_record;
        end
    end

    assign o_record.valid          = r_out_valid;
    assign o_record.record_kind    = r_out.record_kind;
    assign o_record.abbrev_code    = r_out.abbrev_code;
    assign o_record.attribute_code = r_out.attribute_code;
    assign o_record.form_code      = r_out.form_code;

    // The skid stage only fills behind a held output record.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer holds a record ahead of the output register");

    // A record produced under a stall is never dropped.
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && r_out_valid && !o_record.ready) |=> r_skid_valid)
        else $error("record lost while output stalled");

    // A buffered record moves into the output register once it drains.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_record.ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid buffer did not drain");

endmodule

@@ tb/sv/dwarf_abbrev_table_parser_unit_tb.sv @@
// Testbench for the DWARF abbreviation table parser: byte stream in, records checked.
`timescale 1ns / 100ps

module dwarf_abbrev_table_parser_unit_tb;

    // Run time limit in ns, far above the slowest correct run.
    localparam int unsigned RUN_LIMIT_NS = 4_000_000;

    // Decoder position within an abbreviation entry.
    typedef enum logic [2:0] {
        SCAN_CODE,
        SCAN_TAG,
        SCAN_CHILDREN,
        SCAN_ATTR,
        SCAN_FORM
    } t_scan_phase;

    logic i_clk;
    logic i_rst_n;

    dwarf_abp_byte_if section_if ();
    dwarf_abp_rec_if  record_if ();

    dwarf_abbrev_table_parser_unit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_section (section_if),
        .o_record  (record_if)
    );

    // Decoder state mirrored in the testbench.
    t_scan_phase scan_phase;
    logic [31:0] leb_acc;
    logic [2:0]  leb_count;
    logic [31:0] entry_code;
    logic [31:0] held_attr;
    logic        entry_is_cu;
    logic        parse_stopped;

    dwarf_abp_pkg::t_record pending_records[$];
    logic [7:0]             section_buf[$];

    int unsigned bytes_sent;
    int unsigned mismatch_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned recv_hold_cycles;
    int unsigned recv_hold_tag;
    int unsigned recv_hold_seen;
    int unsigned recv_hold_left;

    // Clock: 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic void clear_parse();
        scan_phase    = SCAN_CODE;
        leb_acc       = '0;
        leb_count     = '0;
        entry_code    = '0;
        held_attr     = '0;
        entry_is_cu   = 1'b0;
        parse_stopped = 1'b0;
    endfunction

    function automatic void push_record(logic [1:0] kind, logic [31:0] code,
                                        logic [31:0] attr, logic [31:0] form);
        dwarf_abp_pkg::t_record r;
        r.record_kind    = kind;
        r.abbrev_code    = code;
        r.attribute_code = attr;
        r.form_code      = form;
        pending_records.insert(pending_records.size(), r);
    endfunction

    // Append one byte to the section being built.
    function automatic void add_byte(logic [7:0] b);
        section_buf.insert(section_buf.size(), b);
    endfunction

    // A finishing or failing record quiets the decoder until the section ends.
    function automatic void stop_with(logic [1:0] kind, logic [31:0] code, logic last);
        push_record(kind, code, '0, '0);
        if (last) begin
            clear_parse();
        end else begin
            parse_stopped = 1'b1;
        end
    endfunction

    function automatic void decode_section_byte(logic [7:0] b, logic last);
        logic [31:0] value;
        if (parse_stopped) begin
            if (last) begin
                clear_parse();
            end
            return;
        end

        // The has-children byte is skipped whole.
        if (scan_phase == SCAN_CHILDREN) begin
            if (last) begin
                stop_with(dwarf_abp_pkg::KIND_ERROR, entry_code, 1'b1);
            end else begin
                scan_phase = SCAN_ATTR;
            end
            return;
        end

        // Gather 7 bits per byte, low group first.
        leb_acc = leb_acc | (32'(b[6:0]) << (7 * leb_count));
        if (b[7]) begin
            if (leb_count >= dwarf_abp_pkg::LEB_LAST_IDX || last) begin
                stop_with(dwarf_abp_pkg::KIND_ERROR, entry_code, last);
            end else begin
                leb_count = leb_count + 3'd1;
            end
            return;
        end
        value     = leb_acc;
        leb_acc   = '0;
        leb_count = '0;

        case (scan_phase)
            SCAN_TAG: begin
                if (last) begin
                    stop_with(dwarf_abp_pkg::KIND_ERROR, entry_code, 1'b1);
                end else begin
                    entry_is_cu = (value == dwarf_abp_pkg::TAG_COMPILE_UNIT);
                    scan_phase  = SCAN_CHILDREN;
                end
            end
            SCAN_ATTR: begin
                if (last) begin
                    stop_with(dwarf_abp_pkg::KIND_ERROR, entry_code, 1'b1);
                end else begin
                    held_attr  = value;
                    scan_phase = SCAN_FORM;
                end
            end
            SCAN_FORM: begin
                if (last) begin
                    stop_with(dwarf_abp_pkg::KIND_ERROR, entry_code, 1'b1);
                end else if (held_attr == 0 && value == 0) begin
                    scan_phase = SCAN_CODE;
                    if (entry_is_cu) begin
                        push_record(dwarf_abp_pkg::KIND_ENTRY_END, entry_code, '0, '0);
                    end
                end else if (held_attr == 0 || value == 0) begin
                    stop_with(dwarf_abp_pkg::KIND_ERROR, entry_code, 1'b0);
                end else begin
                    scan_phase = SCAN_ATTR;
                    if (entry_is_cu) begin
                        push_record(dwarf_abp_pkg::KIND_PAIR, entry_code, held_attr, value);
                    end
                end
            end
            default: begin
                if (value == 0) begin
                    stop_with(dwarf_abp_pkg::KIND_TABLE_END, '0, last);
                end else if (last) begin
                    stop_with(dwarf_abp_pkg::KIND_ERROR, entry_code, 1'b1);
                end else begin
                    entry_code = value;
                    scan_phase = SCAN_TAG;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Section generation
    // ------------------------------------------------------------------

    // Nonzero value spread over short, mid-size and full-width encodings.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0:       v = $urandom_range(127, 1);
            1:       v = $urandom_range(16383, 128);
            2:       v = $urandom;
            default: v = ($urandom_range(1) != 0) ? dwarf_abp_pkg::TAG_COMPILE_UNIT
                                                  : 32'hFFFF_FFFF;
        endcase
        if (v == 0) begin
            v = 32'd1;
        end
        return v;
    endfunction

    // Append a LEB128 value, sometimes padded, with junk in the dropped top bits.
    function automatic void push_leb(logic [31:0] value);
        int         len;
        int         i;
        logic [7:0] b;
        len = 1;
        while (len < dwarf_abp_pkg::LEB_MAX_BYTES && (value >> (7 * len)) != 0) begin
            len++;
        end
        if ($urandom_range(4) == 0) begin
            len = $urandom_range(dwarf_abp_pkg::LEB_MAX_BYTES, len);
        end
        for (i = 0; i < len; i++) begin
            b = {1'b0, 7'(value >> (7 * i))};
            if (i == dwarf_abp_pkg::LEB_MAX_BYTES - 1) begin
                b[6:4] = 3'($urandom);
            end
            b[7] = (i < len - 1);
            add_byte(b);
        end
    endfunction

    // Mostly well-formed tables; the rest truncated, corrupted or noise.
    function automatic void build_random_section();
        int          style;
        int          n_entries;
        int          n_pairs;
        int          bad_entry;
        int          bad_pair;
        int          e;
        int          p;
        int          cut;
        logic [31:0] a;
        logic [31:0] f;
        section_buf.delete();
        style = $urandom_range(99);
        if (style >= 94) begin
            repeat ($urandom_range(12, 1)) add_byte(8'($urandom));
            return;
        end
        n_entries = $urandom_range(3, 1);
        bad_entry = $urandom_range(n_entries - 1, 0);
        for (e = 0; e < n_entries; e++) begin
            push_leb(pick_value());
            push_leb(($urandom_range(1) != 0) ? dwarf_abp_pkg::TAG_COMPILE_UNIT
                                              : pick_value());
            add_byte(8'($urandom));
            n_pairs  = $urandom_range(4);
            bad_pair = $urandom_range(n_pairs, 0);
            for (p = 0; p <= n_pairs; p++) begin
                if (e == bad_entry && p == bad_pair && style >= 88) begin
                    // Overlong value: five bytes that all continue.
                    repeat (dwarf_abp_pkg::LEB_MAX_BYTES) add_byte(8'h80 | 8'($urandom));
                end else if (e == bad_entry && p == bad_pair && style >= 80) begin
                    // Pair with exactly one zero half.
                    if ($urandom_range(1) != 0) begin
                        a = '0;
                        f = pick_value();
                    end else begin
                        a = pick_value();
                        f = '0;
                    end
                    push_leb(a);
                    push_leb(f);
                end else if (p == n_pairs) begin
                    push_leb('0);
                    push_leb('0);
                end else begin
                    push_leb(pick_value());
                    push_leb(pick_value());
                end
            end
        end
        push_leb('0);
        if (style < 10) begin
            repeat ($urandom_range(4, 1)) add_byte(8'($urandom));
        end
        if (style >= 70 && style < 80) begin
            cut = $urandom_range(section_buf.size() - 1, 0);
            while (section_buf.size() > cut + 1) begin
                section_buf.delete(section_buf.size() - 1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Section byte driver
    // ------------------------------------------------------------------

    // Offer one byte after a random gap and hold it until the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            section_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        section_if.valid        <= 1'b1;
        section_if.section_byte <= b;
        section_if.section_last <= last;
        do begin
            @(posedge i_clk);
        end while (!section_if.ready);
        decode_section_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_section();
        int i;
        for (i = 0; i < section_buf.size(); i++) begin
            send_byte(section_buf[i], i == section_buf.size() - 1);
        end
    endtask

    task automatic park_input();
        @(negedge i_clk);
        section_if.valid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned n_bytes);
        int unsigned target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            build_random_section();
            send_section();
        end
    endtask

    // ------------------------------------------------------------------
    // Record receiver and checker
    // ------------------------------------------------------------------

    // Ready is random, except during a requested hold-off counted here.
    always @(negedge i_clk) begin
        if (recv_hold_tag != recv_hold_seen) begin
            recv_hold_seen = recv_hold_tag;
            recv_hold_left = recv_hold_cycles;
        end
        if (recv_hold_left != 0) begin
            recv_hold_left = recv_hold_left - 1;
            record_if.ready <= 1'b0;
        end else begin
            record_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Each record beat is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_records
        dwarf_abp_pkg::t_record want;
        if (i_rst_n && record_if.valid && record_if.ready) begin
            if (pending_records.size() == 0) begin
                $error("unexpected record: kind %0d code 0x%08h attr 0x%08h form 0x%08h",
                       record_if.record_kind, record_if.abbrev_code,
                       record_if.attribute_code, record_if.form_code);
                mismatch_count++;
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind", 32'(want.record_kind), 32'(record_if.record_kind));
                check_field("abbrev_code", want.abbrev_code, record_if.abbrev_code);
                check_field("attribute_code", want.attribute_code, record_if.attribute_code);
                check_field("form_code", want.form_code, record_if.form_code);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Complete tables: empty table, widest code, multi-byte form, junk top bits.
    task automatic test_directed_tables();
        section_buf = '{8'h00};
        send_section();
        section_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h11, 8'hFF,
                        8'h7F, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00};
        send_section();
    endtask

    // Half-zero pair, overlong value ending the section, early end on has-children.
    task automatic test_directed_errors();
        section_buf = '{8'h01, 8'h11, 8'h00, 8'h00, 8'h05, 8'h00};
        send_section();
        section_buf = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_section();
        section_buf = '{8'h02, 8'h03, 8'h01};
        send_section();
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(100);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 52;
        recv_stall_pct = 0;
        run_random(100);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        run_random(100);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_random(100);
    endtask

    // Long receiver hold-off while bytes keep coming, so the input stalls.
    task automatic test_output_backpressure();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 300;
        recv_hold_tag    = recv_hold_tag + 1;
        run_random(60);
    endtask

    // Sender waits for every record to drain between sections.
    task automatic test_drain_pause();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        repeat (2) begin
            build_random_section();
            send_section();
            park_input();
            wait (pending_records.size() == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n                 = 1'b0;
        section_if.valid        = 1'b0;
        section_if.section_byte = '0;
        section_if.section_last = 1'b0;
        bytes_sent              = 0;
        mismatch_count          = 0;
        send_idle_pct           = 0;
        recv_stall_pct          = 0;
        recv_hold_cycles        = 0;
        clear_parse();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_tables();
        test_directed_errors();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_backpressure();
        test_drain_pause();

        // Drain, then wait for any stray record.
        park_input();
        recv_stall_pct = 0;
        wait (pending_records.size() == 0);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("dwarf_abbrev_table_parser_unit test passed");
        end else begin
            $display("dwarf_abbrev_table_parser_unit test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(RUN_LIMIT_NS);
        $display("dwarf_abbrev_table_parser_unit test failed");
        $finish;
    end

endmodule
